### rtl/twa_pkg.sv
`timescale 1ns / 1ps
package twa_pkg;

    localparam int TIME_BITS_DEF  = 18;
    localparam int VALUE_BITS_DEF = 16;
    localparam int COUNT_BITS     = 16;
    localparam int CFG_BITS       = 16;
    localparam int CFG_IDX_BITS   = 2;

    localparam logic [CFG_BITS-1:0] WINDOW_LENGTH_RST = 16'd60;
    localparam logic [CFG_BITS-1:0] GAP_LIMIT_RST     = 16'd2560;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WINDOW_LENGTH = 2'd0,
        CFG_GAP_LIMIT     = 2'd1,
        CFG_FILTER_ENABLE = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_DIV   = 2'd1,
        ST_FLUSH = 2'd2
    } twa_state_t;

    typedef struct packed {
        logic running;
        logic done;
    } div_status_t;

endpackage

### rtl/time_window_averager_unit.sv
`timescale 1ns / 1ps
// Tumbling-window averager with jump rejection.
// Input stream s_axis: time stamp and 8.8 value in tdata, tlast marks end of stream.
// Each sample is folded into the open window in the cycle it transfers. A sample
// at or past the window span closes the window; end of stream also flushes the
// open window. Every nonempty closed window produces one result on m_axis: the
// truncated mean time, mean value and the accepted count; tlast marks the last
// result of the run.
// Means come from a bit-serial divider TIME_BITS+16 bits wide (34 at the
// default widths; VALUE_BITS+16 if that is larger). A sample that closes no
// window and ends no stream leaves s_axis_tready high; one closing a nonempty
// window holds it low until its result is loaded; end of stream, until flushed.
// The cfg channel writes window_length (0), gap_limit (1) and filter_enable (2)
// and is always ready; write it only while the block is idle.
// Reset clears the window state and loads the default registers (60 s,
// 10.0 gap, filter on). The result register holds while m_axis_tready is low;
// a further result then waits in the divider and no new sample is taken.
module time_window_averager_unit import twa_pkg::*; #(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // sample_time, sample_value, zero pad
    input  logic [((TIME_BITS+VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                       s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // mean_time, mean_value, sample_count, zero pad
    output logic [((TIME_BITS+VALUE_BITS+COUNT_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic                       m_axis_tlast,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [CFG_BITS-1:0]        cfg_data
);

    localparam int OUT_W      = ((TIME_BITS + VALUE_BITS + COUNT_BITS + 7) / 8) * 8;
    localparam int TSUM_BITS  = TIME_BITS + COUNT_BITS;
    localparam int VSUM_BITS  = VALUE_BITS + COUNT_BITS;
    localparam int DW         = (TSUM_BITS > VSUM_BITS) ? TSUM_BITS : VSUM_BITS;
    localparam int GAP_BITS   = (VALUE_BITS > CFG_BITS) ? VALUE_BITS : CFG_BITS;

    // configuration
    logic [CFG_BITS-1:0] window_length_reg;
    logic [CFG_BITS-1:0] gap_limit_reg;
    logic                filter_enable_reg;

    // window state
    logic                  open_reg, open_next;
    logic [TIME_BITS-1:0]  base_reg, base_next;
    logic [VALUE_BITS-1:0] last_reg, last_next;
    logic [TSUM_BITS-1:0]  tsum_reg, tsum_next;
    logic [VSUM_BITS-1:0]  vsum_reg, vsum_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    twa_state_t state_reg, state_next;
    logic       flush_pend_reg, flush_pend_next;
    logic       final_reg, final_next;

    logic                  m_valid_reg, m_valid_next;
    logic                  m_last_reg;
    logic [TIME_BITS-1:0]  mean_time_reg;
    logic [VALUE_BITS-1:0] mean_value_reg;
    logic [COUNT_BITS-1:0] out_count_reg;
    logic [COUNT_BITS-1:0] job_count_reg, job_count_next;

    // divider hookup
    logic              div_start;
    logic [DW-1:0]     div_a, div_b;
    logic [COUNT_BITS-1:0] div_divisor;
    logic [DW-1:0]     quo_a, quo_b;
    div_status_t       div_status;

    // sample decode
    logic [TIME_BITS-1:0]  in_time;
    logic [VALUE_BITS-1:0] in_value;
    logic                  in_xfer;
    logic                  out_load;
    logic                  out_free;

    logic                  close_win, open_new, take;
    logic [TIME_BITS-1:0]  time_diff;
    logic [VALUE_BITS-1:0] ref_value, gap;
    logic [COUNT_BITS-1:0] count_eff;
    logic [TSUM_BITS-1:0]  tsum_eff;
    logic [VSUM_BITS-1:0]  vsum_eff;

    assign in_time  = s_axis_tdata[TIME_BITS-1:0];
    assign in_value = s_axis_tdata[TIME_BITS+VALUE_BITS-1:TIME_BITS];
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;

    // sample folding
    always_comb
    begin
        time_diff = in_time - base_reg;
        close_win = open_reg && (in_time >= base_reg)
                    && (time_diff >= TIME_BITS'(window_length_reg));
        open_new  = !open_reg || close_win;
        ref_value = open_new ? in_value : last_reg;
        count_eff = open_new ? '0 : count_reg;
        tsum_eff  = open_new ? '0 : tsum_reg;
        vsum_eff  = open_new ? '0 : vsum_reg;
        gap       = (in_value >= ref_value) ? (in_value - ref_value) : (ref_value - in_value);
        take      = (!filter_enable_reg
                     || (GAP_BITS'(gap) < GAP_BITS'(gap_limit_reg)))
                    && (count_eff != '1);
    end

    // control and window update
    always_comb
    begin
        state_next      = state_reg;
        flush_pend_next = flush_pend_reg;
        final_next      = final_reg;
        job_count_next  = job_count_reg;
        open_next       = open_reg;
        base_next       = base_reg;
        last_next       = last_reg;
        tsum_next       = tsum_reg;
        vsum_next       = vsum_reg;
        count_next      = count_reg;
        div_start       = 1'b0;
        div_a           = DW'(tsum_reg);
        div_b           = DW'(vsum_reg);
        div_divisor     = count_reg;
        out_load        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    open_next       = 1'b1;
                    base_next       = open_new ? in_time : base_reg;
                    last_next       = take ? in_value : ref_value;
                    tsum_next       = tsum_eff + (take ? TSUM_BITS'(in_time) : '0);
                    vsum_next       = vsum_eff + (take ? VSUM_BITS'(in_value) : '0);
                    count_next      = count_eff + (take ? COUNT_BITS'(1) : '0);
                    flush_pend_next = s_axis_tlast;
                    if (close_win && (count_reg != '0))
                    begin
                        // divide the closed window from the old sums
                        div_start      = 1'b1;
                        job_count_next = count_reg;
                        final_next     = s_axis_tlast && !take;
                        state_next     = ST_DIV;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_status.done && out_free)
                begin
                    out_load   = 1'b1;
                    state_next = flush_pend_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                flush_pend_next = 1'b0;
                open_next       = 1'b0;
                base_next       = '0;
                last_next       = '0;
                tsum_next       = '0;
                vsum_next       = '0;
                count_next      = '0;
                if (count_reg != '0)
                begin
                    div_start      = 1'b1;
                    job_count_next = count_reg;
                    final_next     = 1'b1;
                    state_next     = ST_DIV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            flush_pend_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            open_reg       <= 1'b0;
            base_reg       <= '0;
            last_reg       <= '0;
            tsum_reg       <= '0;
            vsum_reg       <= '0;
            count_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            flush_pend_reg <= flush_pend_next;
            m_valid_reg    <= m_valid_next;
            open_reg       <= open_next;
            base_reg       <= base_next;
            last_reg       <= last_next;
            tsum_reg       <= tsum_next;
            vsum_reg       <= vsum_next;
            count_reg      <= count_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_LENGTH_RST;
            gap_limit_reg     <= GAP_LIMIT_RST;
            filter_enable_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WINDOW_LENGTH: window_length_reg <= cfg_data;
                CFG_GAP_LIMIT:     gap_limit_reg     <= cfg_data;
                CFG_FILTER_ENABLE: filter_enable_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        final_reg     <= final_next;
        job_count_reg <= job_count_next;
        if (out_load)
        begin
            mean_time_reg  <= quo_a[TIME_BITS-1:0];
            mean_value_reg <= quo_b[VALUE_BITS-1:0];
            out_count_reg  <= job_count_reg;
            m_last_reg     <= final_reg;
        end
    end

    twa_divider #(
        .DW (DW)
    ) u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .dividend_a (div_a),
        .dividend_b (div_b),
        .divisor    (div_divisor),
        .quotient_a (quo_a),
        .quotient_b (quo_b),
        .status     (div_status)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = OUT_W'({out_count_reg, mean_value_reg, mean_time_reg});

`ifndef SYNTHESIS
    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !div_status.running)
        else $error("divider running while idle");

    a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (out_count_reg != '0))
        else $error("result from an empty window");

    a_count_needs_window: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> open_reg)
        else $error("samples counted with no open window");

    a_flush_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        flush_pend_reg |-> (state_reg != ST_IDLE))
        else $error("flush pending while idle");

    a_div_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(div_status.running && div_status.done))
        else $error("divider running and done together");
`endif

endmodule

### rtl/twa_divider.sv
`timescale 1ns / 1ps
// Two restoring dividers sharing one divisor, one quotient bit per cycle each.
module twa_divider import twa_pkg::*; #(
    parameter int DW = TIME_BITS_DEF + COUNT_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DW-1:0]         dividend_a,
    input  logic [DW-1:0]         dividend_b,
    input  logic [COUNT_BITS-1:0] divisor,
    output logic [DW-1:0]         quotient_a,
    output logic [DW-1:0]         quotient_b,
    output div_status_t           status
);

    localparam int STEP_BITS = $clog2(DW + 1);

    logic [DW-1:0]         quo_a_reg, quo_a_next;
    logic [DW-1:0]         quo_b_reg, quo_b_next;
    logic [COUNT_BITS-1:0] rem_a_reg, rem_a_next;
    logic [COUNT_BITS-1:0] rem_b_reg, rem_b_next;
    logic [COUNT_BITS-1:0] div_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic                  running_reg;
    logic                  done_reg;

    logic [COUNT_BITS:0] shift_a, shift_b;
    logic [COUNT_BITS:0] diff_a, diff_b;

    always_comb
    begin
        // bring down the next dividend bit and try the subtract
        shift_a = {rem_a_reg, quo_a_reg[DW-1]};
        shift_b = {rem_b_reg, quo_b_reg[DW-1]};
        diff_a  = shift_a - {1'b0, div_reg};
        diff_b  = shift_b - {1'b0, div_reg};
        if (shift_a >= {1'b0, div_reg})
        begin
            rem_a_next = diff_a[COUNT_BITS-1:0];
            quo_a_next = {quo_a_reg[DW-2:0], 1'b1};
        end
        else
        begin
            rem_a_next = shift_a[COUNT_BITS-1:0];
            quo_a_next = {quo_a_reg[DW-2:0], 1'b0};
        end
        if (shift_b >= {1'b0, div_reg})
        begin
            rem_b_next = diff_b[COUNT_BITS-1:0];
            quo_b_next = {quo_b_reg[DW-2:0], 1'b1};
        end
        else
        begin
            rem_b_next = shift_b[COUNT_BITS-1:0];
            quo_b_next = {quo_b_reg[DW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= '0;
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else if (start)
        begin
            step_reg    <= STEP_BITS'(DW);
            running_reg <= 1'b1;
            done_reg    <= 1'b0;
        end
        else if (running_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_BITS'(1))
            begin
                running_reg <= 1'b0;
                done_reg    <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_a_reg <= dividend_a;
            quo_b_reg <= dividend_b;
            rem_a_reg <= '0;
            rem_b_reg <= '0;
            div_reg   <= divisor;
        end
        else if (running_reg)
        begin
            quo_a_reg <= quo_a_next;
            quo_b_reg <= quo_b_next;
            rem_a_reg <= rem_a_next;
            rem_b_reg <= rem_b_next;
        end
    end

    assign quotient_a     = quo_a_reg;
    assign quotient_b     = quo_b_reg;
    assign status.running = running_reg;
    assign status.done    = done_reg;

endmodule
